FILE: rtl/assert_macros.svh
// assertion macros shared by the sampler rtl
// used by gcs_ctrl and gcs_dp; expects clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define GCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define GCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/gcs_pkg.sv
// shared types and constants for the grid cdf sampler
// no dependencies; imported by every rtl module of the block
package gcs_pkg;

  // default grid geometry and weight width
  localparam int DefMaxCellsX       = 16;
  localparam int DefMaxCellsY       = 16;
  localparam int DefMaxCellsHeading = 16;
  localparam int DefWeightBits      = 32;

  // size registers: 5 bits, largest usable value, reset value
  localparam int SizeW     = 5;
  localparam int SizeLimit = 31;
  localparam int SizeReset = 16;

  // 0.9999 as 65529 / 65536
  localparam logic [15:0] ScaleNum = 16'd65529;

  // stream packing widths
  localparam int InTdataW  = 64;
  localparam int OutTdataW = 16;

  // apb register map
  localparam int PaddrW = 4;
  localparam int PdataW = 32;
  localparam logic [1:0] REG_CELLS_X       = 2'd0;
  localparam logic [1:0] REG_CELLS_Y       = 2'd1;
  localparam logic [1:0] REG_CELLS_HEADING = 2'd2;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RES_FOUND    = 2'd0,
    RES_FALLBACK = 2'd1,
    RES_EMPTY    = 2'd2
  } res_status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_READ,
    ST_WR_UPDATE,
    ST_THR_SCALE,
    ST_THR_LO,
    ST_THR_HI,
    ST_THR_SUM,
    ST_SCAN,
    ST_DONE_FOUND,
    ST_DONE_FALLBACK,
    ST_DONE_EMPTY
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic        cap;
    logic        clr_step;
    logic        wr_read;
    logic        wr_update;
    logic        thr_scale;
    logic        thr_lo;
    logic        thr_hi;
    logic        thr_sum;
    logic        scan_init;
    logic        scan_run;
    logic        res_load;
    res_status_e res_code;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic wr_inrange;
    logic total_zero;
    logic size_zero;
    logic scan_hit;
    logic scan_miss;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/gcs_regs.sv
// apb register file holding the three grid size registers
// depends on gcs_pkg; written values saturate to the grid limits
module gcs_regs import gcs_pkg::*; #(
  parameter int MAX_CELLS_X       = DefMaxCellsX,
  parameter int MAX_CELLS_Y       = DefMaxCellsY,
  parameter int MAX_CELLS_HEADING = DefMaxCellsHeading
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic [SizeW-1:0]  cells_x_o,
  output logic [SizeW-1:0]  cells_y_o,
  output logic [SizeW-1:0]  cells_heading_o
);

  localparam int EffX = (MAX_CELLS_X < SizeLimit) ? MAX_CELLS_X : SizeLimit;
  localparam int EffY = (MAX_CELLS_Y < SizeLimit) ? MAX_CELLS_Y : SizeLimit;
  localparam int EffH = (MAX_CELLS_HEADING < SizeLimit) ? MAX_CELLS_HEADING : SizeLimit;
  localparam logic [SizeW-1:0] ClampX = SizeW'(EffX);
  localparam logic [SizeW-1:0] ClampY = SizeW'(EffY);
  localparam logic [SizeW-1:0] ClampH = SizeW'(EffH);
  localparam logic [SizeW-1:0] RstX = SizeW'((SizeReset < EffX) ? SizeReset : EffX);
  localparam logic [SizeW-1:0] RstY = SizeW'((SizeReset < EffY) ? SizeReset : EffY);
  localparam logic [SizeW-1:0] RstH = SizeW'((SizeReset < EffH) ? SizeReset : EffH);

  logic [SizeW-1:0] cells_x_q, cells_y_q, cells_h_q;
  logic [SizeW-1:0] wval;
  logic [1:0]       reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wval    = pwdata[SizeW-1:0];
  assign wr_en   = psel && penable && pwrite;

  // size registers, saturated on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= RstX;
      cells_y_q <= RstY;
      cells_h_q <= RstH;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CELLS_X:       cells_x_q <= (wval > ClampX) ? ClampX : wval;
        REG_CELLS_Y:       cells_y_q <= (wval > ClampY) ? ClampY : wval;
        REG_CELLS_HEADING: cells_h_q <= (wval > ClampH) ? ClampH : wval;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_CELLS_X:       prdata = PdataW'(cells_x_q);
      REG_CELLS_Y:       prdata = PdataW'(cells_y_q);
      REG_CELLS_HEADING: prdata = PdataW'(cells_h_q);
      default:           prdata = '0;
    endcase
  end

  assign cells_x_o       = cells_x_q;
  assign cells_y_o       = cells_y_q;
  assign cells_heading_o = cells_h_q;

endmodule

FILE: rtl/gcs_ctrl.sv
// controller state machine of the grid cdf sampler
// depends on gcs_pkg and assert_macros.svh; drives gcs_dp through cmd_t
`include "assert_macros.svh"
module gcs_ctrl import gcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  input  op_e  op_i,
  output logic s_tready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          if (op_i == OP_WRITE) state_d = ST_WR_READ;
          else if (sts_i.total_zero) state_d = ST_DONE_EMPTY;
          else state_d = ST_THR_SCALE;
        end
      end
      ST_WR_READ:   state_d = sts_i.wr_inrange ? ST_WR_UPDATE : ST_IDLE;
      ST_WR_UPDATE: state_d = ST_IDLE;
      ST_THR_SCALE: state_d = ST_THR_LO;
      ST_THR_LO:    state_d = ST_THR_HI;
      ST_THR_HI:    state_d = ST_THR_SUM;
      ST_THR_SUM:   state_d = sts_i.size_zero ? ST_DONE_FALLBACK : ST_SCAN;
      ST_SCAN: begin
        if (sts_i.scan_hit) state_d = ST_DONE_FOUND;
        else if (sts_i.scan_miss) state_d = ST_DONE_FALLBACK;
      end
      ST_DONE_FOUND, ST_DONE_FALLBACK, ST_DONE_EMPTY: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.res_code = RES_FOUND;
    s_tready_o     = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.cap  = s_tvalid_i;
      end
      ST_WR_READ:   cmd_o.wr_read   = 1'b1;
      ST_WR_UPDATE: cmd_o.wr_update = 1'b1;
      ST_THR_SCALE: cmd_o.thr_scale = 1'b1;
      ST_THR_LO:    cmd_o.thr_lo    = 1'b1;
      ST_THR_HI:    cmd_o.thr_hi    = 1'b1;
      ST_THR_SUM: begin
        cmd_o.thr_sum   = 1'b1;
        cmd_o.scan_init = 1'b1;
      end
      ST_SCAN: cmd_o.scan_run = 1'b1;
      ST_DONE_FOUND: begin
        cmd_o.res_load = sts_i.out_free;
        cmd_o.res_code = RES_FOUND;
      end
      ST_DONE_FALLBACK: begin
        cmd_o.res_load = sts_i.out_free;
        cmd_o.res_code = RES_FALLBACK;
      end
      ST_DONE_EMPTY: begin
        cmd_o.res_load = sts_i.out_free;
        cmd_o.res_code = RES_EMPTY;
      end
      default: ;
    endcase
  end

  // an accepted request always leaves idle
  `GCS_ASSERT(a_accept_leaves_idle, (state_q == ST_IDLE && s_tvalid_i) |=> (state_q != ST_IDLE), "request accepted but controller stayed idle")
  // no request is taken while reset is held
  `GCS_ASSERT_ALWAYS(a_no_ready_in_reset, !rst_ni |-> !s_tready_o, "ready during reset")
  // a result is loaded only into a free output register
  `GCS_ASSERT(a_load_when_free, cmd_o.res_load |-> sts_i.out_free, "result load while busy")

endmodule

FILE: rtl/gcs_dp.sv
// datapath of the grid cdf sampler: weight memory, total, threshold, scan, result
// depends on gcs_pkg and assert_macros.svh; sequenced by gcs_ctrl
`include "assert_macros.svh"
module gcs_dp import gcs_pkg::*; #(
  parameter int MAX_CELLS_X       = DefMaxCellsX,
  parameter int MAX_CELLS_Y       = DefMaxCellsY,
  parameter int MAX_CELLS_HEADING = DefMaxCellsHeading,
  parameter int WEIGHT_BITS       = DefWeightBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic [SizeW-1:0] cells_x_i,
  input  logic [SizeW-1:0] cells_y_i,
  input  logic [SizeW-1:0] cells_heading_i,
  input  logic [3:0]       cell_x_i,
  input  logic [3:0]       cell_y_i,
  input  logic [3:0]       cell_heading_i,
  input  logic [31:0]      weight_i,
  input  logic [15:0]      random_fraction_i,
  input  logic             m_tready_i,
  output logic             m_tvalid_o,
  output logic [3:0]       sample_x_o,
  output logic [3:0]       sample_y_o,
  output logic [3:0]       sample_heading_o,
  output res_status_e      status_o
);

  localparam int Depth = MAX_CELLS_X * MAX_CELLS_Y * MAX_CELLS_HEADING;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int TwRaw = WEIGHT_BITS + $clog2(Depth);
  localparam int TW    = (TwRaw > 64) ? 64 : TwRaw;
  localparam int EffX  = (MAX_CELLS_X < SizeLimit) ? MAX_CELLS_X : SizeLimit;
  localparam int EffY  = (MAX_CELLS_Y < SizeLimit) ? MAX_CELLS_Y : SizeLimit;
  localparam int EffH  = (MAX_CELLS_HEADING < SizeLimit) ? MAX_CELLS_HEADING : SizeLimit;
  localparam int XW    = (EffX > 1) ? $clog2(EffX) : 1;
  localparam int YW    = (EffY > 1) ? $clog2(EffY) : 1;
  localparam int HW    = (EffH > 1) ? $clog2(EffH) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  // captured request
  logic [3:0]             in_x_q, in_y_q, in_h_q;
  logic [WEIGHT_BITS-1:0] in_w_q;
  logic [15:0]            in_r_q;

  // weight memory
  logic [WEIGHT_BITS-1:0] mem [Depth];
  logic [WEIGHT_BITS-1:0] rdata_q;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          waddr, raddr, wr_addr, scan_addr;
  logic [WEIGHT_BITS-1:0] wdata;

  // clearing pass
  logic [AW-1:0] clr_addr_q;

  // running total and threshold
  logic [TW-1:0] total_q, t_q;
  logic [63:0]   tot64;
  logic [31:0]   p_q;
  logic [63:0]   plo_q, phi_q;

  // scan state
  logic [XW-1:0] sx_q, ev_x_q, hit_x_q;
  logic [YW-1:0] sy_q, ev_y_q, hit_y_q;
  logic [HW-1:0] sh_q, ev_h_q, hit_h_q;
  logic          issue_act_q, ev_valid_q, ev_last_q;
  logic          x_last, y_last, h_last, issue;
  logic [TW-1:0] cum_q, cum_next;
  logic          hit;

  // result register
  logic             out_valid_q;
  logic [3:0]       out_x_q, out_y_q, out_h_q;
  res_status_e      out_st_q;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      in_x_q <= cell_x_i;
      in_y_q <= cell_y_i;
      in_h_q <= cell_heading_i;
      in_w_q <= WEIGHT_BITS'(weight_i);
      in_r_q <= random_fraction_i;
    end
  end

  // addresses: heading outermost, then y, then x
  assign wr_addr = AW'((32'(in_h_q) * 32'(MAX_CELLS_Y) + 32'(in_y_q)) * 32'(MAX_CELLS_X)
                       + 32'(in_x_q));
  assign scan_addr = AW'((32'(sh_q) * 32'(MAX_CELLS_Y) + 32'(sy_q)) * 32'(MAX_CELLS_X)
                         + 32'(sx_q));

  assign issue  = cmd_i.scan_run && issue_act_q;
  assign mem_we = cmd_i.clr_step || cmd_i.wr_update;
  assign waddr  = cmd_i.clr_step ? clr_addr_q : wr_addr;
  assign wdata  = cmd_i.clr_step ? '0 : in_w_q;
  assign mem_re = cmd_i.wr_read || issue;
  assign raddr  = cmd_i.wr_read ? wr_addr : scan_addr;

  // memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_q <= mem[raddr];
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // running total, replaces the old cell weight with the new one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.wr_update) begin
      total_q <= total_q - TW'(rdata_q) + TW'(in_w_q);
    end
  end

  // threshold ceil(p * total / 2^32) over four steps
  assign tot64 = 64'(total_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.thr_scale) p_q   <= 32'(in_r_q) * 32'(ScaleNum);
    if (cmd_i.thr_lo)    plo_q <= 64'(p_q) * 64'(tot64[31:0]);
    if (cmd_i.thr_hi)    phi_q <= 64'(p_q) * 64'(tot64[63:32]);
    if (cmd_i.thr_sum)   t_q   <= TW'(phi_q + 64'(plo_q[63:32]) + 64'(|plo_q[31:0]));
  end

  // scan counter wrap points
  assign x_last = (SizeW'(sx_q) == cells_x_i - SizeW'(1));
  assign y_last = (SizeW'(sy_q) == cells_y_i - SizeW'(1));
  assign h_last = (SizeW'(sh_q) == cells_heading_i - SizeW'(1));

  // scan issue side: walk the cells, one read a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_act_q <= 1'b0;
      ev_valid_q  <= 1'b0;
      ev_last_q   <= 1'b0;
    end else if (cmd_i.scan_init) begin
      issue_act_q <= 1'b1;
      ev_valid_q  <= 1'b0;
      ev_last_q   <= 1'b0;
    end else if (cmd_i.scan_run) begin
      ev_valid_q <= issue;
      ev_last_q  <= issue && x_last && y_last && h_last;
      if (issue && x_last && y_last && h_last) issue_act_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      sx_q <= '0;
      sy_q <= '0;
      sh_q <= '0;
    end else if (issue) begin
      ev_x_q <= sx_q;
      ev_y_q <= sy_q;
      ev_h_q <= sh_q;
      if (!x_last) begin
        sx_q <= sx_q + XW'(1);
      end else begin
        sx_q <= '0;
        if (!y_last) begin
          sy_q <= sy_q + YW'(1);
        end else begin
          sy_q <= '0;
          sh_q <= sh_q + HW'(1);
        end
      end
    end
  end

  // scan evaluate side: accumulate and compare against the threshold
  assign cum_next = cum_q + TW'(rdata_q);
  assign hit      = (t_q <= cum_next);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      cum_q <= '0;
    end else if (cmd_i.scan_run && ev_valid_q) begin
      cum_q <= cum_next;
      if (hit) begin
        hit_x_q <= ev_x_q;
        hit_y_q <= ev_y_q;
        hit_h_q <= ev_h_q;
      end
    end
  end

  // result register, decouples the scan from a stalled receiver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_st_q <= cmd_i.res_code;
      if (cmd_i.res_code == RES_FOUND) begin
        out_x_q <= 4'(hit_x_q);
        out_y_q <= 4'(hit_y_q);
        out_h_q <= 4'(hit_h_q);
      end else begin
        out_x_q <= '0;
        out_y_q <= '0;
        out_h_q <= '0;
      end
    end
  end

  assign m_tvalid_o       = out_valid_q;
  assign sample_x_o       = out_x_q;
  assign sample_y_o       = out_y_q;
  assign sample_heading_o = out_h_q;
  assign status_o         = out_st_q;

  // status back to the controller
  always_comb begin
    sts_o.clr_last   = (clr_addr_q == LastAddr);
    sts_o.wr_inrange = (SizeW'(in_x_q) < cells_x_i) && (SizeW'(in_y_q) < cells_y_i)
                       && (SizeW'(in_h_q) < cells_heading_i);
    sts_o.total_zero = (total_q == '0);
    sts_o.size_zero  = (cells_x_i == '0) || (cells_y_i == '0) || (cells_heading_i == '0);
    sts_o.scan_hit   = cmd_i.scan_run && ev_valid_q && hit;
    sts_o.scan_miss  = cmd_i.scan_run && ev_valid_q && ev_last_q && !hit;
    sts_o.out_free   = !out_valid_q || m_tready_i;
  end

  // a new result never overwrites one still waiting
  `GCS_ASSERT(a_res_slot_free, cmd_i.res_load |-> (!out_valid_q || m_tready_i), "result loaded over a pending one")
  // the threshold never exceeds the total while scanning
  `GCS_ASSERT(a_thr_le_total, cmd_i.scan_run |-> (t_q <= total_q), "threshold above total weight")
  // issuing stops only after the last cell went out
  `GCS_ASSERT(a_issue_stop_last, $fell(issue_act_q) |-> ev_last_q, "scan stopped before the last cell")

endmodule

FILE: rtl/grid_cdf_sampler_core.sv
// grid cdf sampler, top level: apb size registers, controller and datapath
// depends on gcs_pkg, gcs_regs, gcs_ctrl and gcs_dp
//
// Usage: requests come in on the s_axis channel. tuser picks the kind: 0 writes
// one cell weight (no response), 1 draws a sample from the random fraction.
// Each sample gives one response on m_axis: chosen x, y, heading in tdata
// and the status in tuser (0 found, 1 fallback with zero indices, 2 empty grid).
// Grid sizes are set over apb at byte offsets 0, 4, 8; the user must set them
// only while the block is idle, which the block does not enforce. A write request
// is accepted, reads the old weight, then updates memory and total; one that lies
// outside the grid is dropped after the read. A sample is accepted, runs the four
// threshold steps, scans the cells and ends with the result load; the single read
// port of the weight memory sets the one cell per cycle pace of the scan. Samples
// on an empty grid go straight to the result load; with a zero grid size they run
// the threshold steps and fall back. After reset the memory is zeroed by a
// clearing pass of one entry per cycle, during which s_axis_tready stays low.
// Results sit in an output register: the next request is accepted while a
// result waits; a finished sample waits only if that register is still full.
module grid_cdf_sampler_core import gcs_pkg::*; #(
  parameter int MAX_CELLS_X       = DefMaxCellsX,
  parameter int MAX_CELLS_Y       = DefMaxCellsY,
  parameter int MAX_CELLS_HEADING = DefMaxCellsHeading,
  parameter int WEIGHT_BITS       = DefWeightBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: cell_x[3:0], cell_y[7:4], cell_heading[11:8], weight[43:12],
  // random_fraction[59:44], zero[63:60]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // tuser: operation[0]
  input  logic                 s_axis_tuser,
  // response channel
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: sample_x[3:0], sample_y[7:4], sample_heading[11:8], zero[15:12]
  output logic [OutTdataW-1:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]           m_axis_tuser,
  // apb configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [PdataW-1:0]    pwdata,
  output logic [PdataW-1:0]    prdata,
  output logic                 pready
);

  logic [SizeW-1:0] cells_x, cells_y, cells_h;
  cmd_t             cmd;
  sts_t             sts;
  logic [3:0]       smp_x, smp_y, smp_h;
  res_status_e      smp_st;
  op_e              op;

  assign op = op_e'(s_axis_tuser);

  // size registers
  gcs_regs #(
    .MAX_CELLS_X      (MAX_CELLS_X),
    .MAX_CELLS_Y      (MAX_CELLS_Y),
    .MAX_CELLS_HEADING(MAX_CELLS_HEADING)
  ) u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cells_x_o      (cells_x),
    .cells_y_o      (cells_y),
    .cells_heading_o(cells_h)
  );

  // sequencing
  gcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .op_i      (op),
    .s_tready_o(s_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // memory, arithmetic and result register
  gcs_dp #(
    .MAX_CELLS_X      (MAX_CELLS_X),
    .MAX_CELLS_Y      (MAX_CELLS_Y),
    .MAX_CELLS_HEADING(MAX_CELLS_HEADING),
    .WEIGHT_BITS      (WEIGHT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cells_x_i        (cells_x),
    .cells_y_i        (cells_y),
    .cells_heading_i  (cells_h),
    .cell_x_i         (s_axis_tdata[3:0]),
    .cell_y_i         (s_axis_tdata[7:4]),
    .cell_heading_i   (s_axis_tdata[11:8]),
    .weight_i         (s_axis_tdata[43:12]),
    .random_fraction_i(s_axis_tdata[59:44]),
    .m_tready_i       (m_axis_tready),
    .m_tvalid_o       (m_axis_tvalid),
    .sample_x_o       (smp_x),
    .sample_y_o       (smp_y),
    .sample_heading_o (smp_h),
    .status_o         (smp_st)
  );

  // response packing
  assign m_axis_tdata = {4'b0000, smp_h, smp_y, smp_x};
  assign m_axis_tuser = smp_st;

endmodule
